>>> hw/rtl/swrms_pkg.sv
// Shared constants and controller command type for the sliding-window RMS level unit
package swrms_pkg;

  // default window length in samples and default sample width
  localparam int unsigned WINDOW_DEF      = 2400;
  localparam int unsigned SAMPLE_BITS_DEF = 16;

  // fixed port widths
  localparam int unsigned IN_W    = 16;
  localparam int unsigned LEVEL_W = 16;

  // commands from the controller to the datapath, at most one per cycle
  typedef struct packed {
    logic accept;      // latch sample, issue ring read
    logic square;      // square new and oldest sample
    logic update;      // update sum, write ring, advance pointer
    logic root_init;   // load square root unit from sum
    logic root_step;   // one root bit
    logic load_level;  // move root into the output register
  } swrms_cmd_t;

endpackage

>>> hw/rtl/swrms_ctrl.sv
// Controller state machine for the sliding-window RMS level unit
module swrms_ctrl #(
  parameter int unsigned SAMPLE_BITS = swrms_pkg::SAMPLE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   sample_valid,
  output logic                   sample_stall,
  output logic                   level_valid,
  input  logic                   level_stall,
  output swrms_pkg::swrms_cmd_t  cmd
);
  import swrms_pkg::*;

  localparam int unsigned CNT_W = $clog2(SAMPLE_BITS);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SQUARE,
    S_UPDATE,
    S_ROOT_PREP,
    S_ROOT,
    S_DONE
  } state_t;

  state_t             state;
  logic [CNT_W-1:0]   cnt;
  logic               out_free;

  assign out_free     = !level_valid || !level_stall;
  assign sample_stall = (state != S_IDLE);

  // command decode
  always_comb begin
    cmd = '0;
    unique case (state)
      S_IDLE:      cmd.accept     = sample_valid;
      S_SQUARE:    cmd.square     = 1'b1;
      S_UPDATE:    cmd.update     = 1'b1;
      S_ROOT_PREP: cmd.root_init  = 1'b1;
      S_ROOT:      cmd.root_step  = 1'b1;
      S_DONE:      cmd.load_level = out_free;
      default:     cmd = '0;
    endcase
  end

  // sequencer and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      cnt         <= '0;
      level_valid <= 1'b0;
    end else begin
      if (cmd.load_level) begin
        level_valid <= 1'b1;
      end else if (level_valid && !level_stall) begin
        level_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (sample_valid) state <= S_SQUARE;
        end
        S_SQUARE: state <= S_UPDATE;
        S_UPDATE: state <= S_ROOT_PREP;
        S_ROOT_PREP: begin
          state <= S_ROOT;
          cnt   <= CNT_W'(SAMPLE_BITS - 1);
        end
        S_ROOT: begin
          if (cnt == '0) state <= S_DONE;
          else cnt <= cnt - 1'b1;
        end
        S_DONE: begin
          if (out_free) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> hw/rtl/swrms_datapath.sv
// Datapath: sample ring, square sum and bit-serial square root scaled by the window
module swrms_datapath #(
  parameter int unsigned WINDOW      = swrms_pkg::WINDOW_DEF,
  parameter int unsigned SAMPLE_BITS = swrms_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  swrms_pkg::swrms_cmd_t                cmd,
  input  logic signed [swrms_pkg::IN_W-1:0]    sample,
  output logic        [swrms_pkg::LEVEL_W-1:0] level
);
  import swrms_pkg::*;

  localparam int unsigned SB     = SAMPLE_BITS;
  localparam int unsigned SQ_W   = 2 * SB - 1;
  localparam int unsigned WIN_W  = $clog2(WINDOW + 1);
  localparam int unsigned SUM_W  = SQ_W + WIN_W;
  localparam int unsigned PTR_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam logic [SUM_W-1:0] BIT_TOP  = SUM_W'(WINDOW) << (2 * (SB - 1));
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(WINDOW - 1);

  // sample ring, no reset: slots not yet written are masked by wrapped
  logic signed [SB-1:0] ring [WINDOW];

  logic signed [SB-1:0]     smp;
  logic signed [SB-1:0]     rdata;
  logic        [SQ_W-1:0]   new_sq;
  logic        [SQ_W-1:0]   old_sq;
  logic        [SUM_W-1:0]  sum;
  logic        [PTR_W-1:0]  ptr;
  logic                     wrapped;
  logic        [SUM_W-1:0]  rem;
  logic        [SUM_W-1:0]  win_root;
  logic        [SUM_W-1:0]  win_bit;
  logic        [SB-1:0]     root;

  logic signed [2*SB-1:0]   prod_new;
  logic signed [2*SB-1:0]   prod_old;
  logic        [SUM_W:0]    root_trial;
  logic                     root_ge;

  // squares of the newest and the oldest sample
  assign prod_new = smp * smp;
  assign prod_old = rdata * rdata;

  // root step on the sum itself: the bit is kept when WINDOW * root^2 <= sum,
  // which gives floor(sqrt(floor(sum / WINDOW))) with no division
  // rem = sum - WINDOW * root^2, win_root = WINDOW * root at the bit position,
  // win_bit = WINDOW * 4^bit
  assign root_trial = {1'b0, win_root} + {1'b0, win_bit};
  assign root_ge    = ({1'b0, rem} >= root_trial);

  // ring read and write
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      rdata <= ring[ptr];
    end
    if (cmd.update) begin
      ring[ptr] <= smp;
    end
  end

  // window state: sum of squares, write pointer, first-pass flag
  always_ff @(posedge clk) begin
    if (rst) begin
      sum     <= '0;
      ptr     <= '0;
      wrapped <= 1'b0;
    end else if (cmd.update) begin
      sum <= sum - SUM_W'(old_sq) + SUM_W'(new_sq);
      if (ptr == PTR_LAST) begin
        ptr     <= '0;
        wrapped <= 1'b1;
      end else begin
        ptr <= ptr + 1'b1;
      end
    end
  end

  // arithmetic working registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      smp <= SB'($unsigned(sample));
    end
    if (cmd.square) begin
      new_sq <= prod_new[SQ_W-1:0];
      old_sq <= wrapped ? prod_old[SQ_W-1:0] : '0;
    end
    if (cmd.root_init) begin
      rem      <= sum;
      win_root <= '0;
      win_bit  <= BIT_TOP;
      root     <= '0;
    end else if (cmd.root_step) begin
      rem      <= root_ge ? (rem - root_trial[SUM_W-1:0]) : rem;
      win_root <= (win_root >> 1) + (root_ge ? win_bit : '0);
      win_bit  <= win_bit >> 2;
      root     <= {root[SB-2:0], root_ge};
    end
    if (cmd.load_level) begin
      level <= LEVEL_W'(root);
    end
  end

endmodule

>>> hw/rtl/sliding_window_rms_level_unit.sv
// Top level of the sliding-window RMS level unit
//
// Each sample word goes into a ring of the newest WINDOW samples and a running
// sum of their squares; the result word is floor(sqrt(floor(sum / WINDOW))) in
// Q15 units. Slots not yet written count as zero, so the level ramps up over
// the first WINDOW samples; no clearing pass is needed after reset. The division
// by WINDOW is folded into the square root, which tests WINDOW * root^2 against
// the sum and settles one root bit per cycle. Each sample word is latched, then it
// and the oldest sample are squared and folded into the sum, and its root is settled
// bit by bit. A new sample is taken as soon as the previous result sits in the output
// register, even if it has not been taken yet; while that result waits, the next
// one is held back and the input stays stalled.
module sliding_window_rms_level_unit #(
  parameter int unsigned WINDOW      = swrms_pkg::WINDOW_DEF,
  parameter int unsigned SAMPLE_BITS = swrms_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic signed [swrms_pkg::IN_W-1:0]    sample,
  input  logic                                 sample_valid,
  output logic                                 sample_stall,
  output logic        [swrms_pkg::LEVEL_W-1:0] level,
  output logic                                 level_valid,
  input  logic                                 level_stall
);
  import swrms_pkg::*;

  swrms_cmd_t cmd;

  // sequencer
  swrms_ctrl #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .level_valid  (level_valid),
    .level_stall  (level_stall),
    .cmd          (cmd)
  );

  // ring, sum and arithmetic
  swrms_datapath #(
    .WINDOW      (WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_datapath (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .sample (sample),
    .level  (level)
  );

`ifndef SYNTHESIS
  // an accepted word blocks the input until its result is done
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    sample_valid && !sample_stall |=> sample_stall)
    else $error("input not stalled after accepted word");

  // the datapath gets at most one command per cycle
  a_cmd_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot0(cmd))
    else $error("more than one datapath command");

  // a new level never overwrites a result still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load_level |-> !(level_valid && level_stall))
    else $error("pending level overwritten");

  // a loaded level shows up as valid in the next cycle
  a_load_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.load_level |=> level_valid)
    else $error("loaded level not presented");
`endif

endmodule

>>> tb/sliding_window_rms_level_unit_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for the sliding-window RMS level unit
module sliding_window_rms_level_unit_test;
  import swrms_pkg::*;

  localparam int unsigned WINDOW = WINDOW_DEF;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int DRAIN_CYCLES = 3 * SAMPLE_BITS_DEF + 5 + 50;
  localparam int CYCLE_LIMIT = 1500000;
  localparam int DIRECTED_ROWS = 20;

  typedef enum {SEG_FULL_RANGE, SEG_QUIET, SEG_LOUD, SEG_FULL_SCALE_NEG} segment_kind_t;

  typedef struct {
    logic signed [IN_W-1:0] value;
    bit known;
    logic [LEVEL_W-1:0] level;
  } sample_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic signed [IN_W-1:0] sample = '0;
  logic sample_valid = 1'b0;
  logic sample_stall;
  logic [LEVEL_W-1:0] level;
  logic level_valid;
  logic level_stall = 1'b0;

  // copy of the window, write slot and running energy
  logic signed [IN_W-1:0] window_copy [WINDOW];
  int unsigned next_slot;
  logic [63:0] energy_sum;

  logic [LEVEL_W-1:0] pending_levels [$];
  sample_row_t directed_rows [DIRECTED_ROWS];
  int fail_count = 0;
  int cycle_count = 0;
  int send_idle_pct = 0;
  int level_stall_pct = 0;
  int hold_left = 0;
  bit start_hold = 1'b0;

  sliding_window_rms_level_unit dut (
    .clk(clk),
    .rst(rst),
    .sample(sample),
    .sample_valid(sample_valid),
    .sample_stall(sample_stall),
    .level(level),
    .level_valid(level_valid),
    .level_stall(level_stall)
  );

  always #1 clk = ~clk;

  // floored square root, one bit at a time from the top
  function automatic logic [31:0] floor_root(input logic [63:0] x);
    logic [31:0] root;
    logic [31:0] trial;
    root = '0;
    for (int b = 31; b >= 0; b--) begin
      trial = root | (32'd1 << b);
      if (64'(trial) * 64'(trial) <= x) root = trial;
    end
    return root;
  endfunction

  // push one sample into the window and return the new rms level
  function automatic logic [LEVEL_W-1:0] rms_after(input logic signed [IN_W-1:0] s);
    logic signed [IN_W-1:0] oldest;
    logic [63:0] mean;
    logic [31:0] root;
    oldest = window_copy[next_slot];
    energy_sum = energy_sum - 64'(longint'(oldest) * longint'(oldest))
                 + 64'(longint'(s) * longint'(s));
    window_copy[next_slot] = s;
    next_slot = (next_slot == WINDOW - 1) ? 0 : next_slot + 1;
    mean = energy_sum / WINDOW;
    root = floor_root(mean);
    return root[LEVEL_W-1:0];
  endfunction

  // offer one sample word, wait for it to be taken, record the expected level
  task automatic send_sample(input logic signed [IN_W-1:0] s, input bit known,
                             input logic [LEVEL_W-1:0] typed_level);
    logic [LEVEL_W-1:0] predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      sample_valid <= 1'b0;
      @(posedge clk);
    end
    sample <= s;
    sample_valid <= 1'b1;
    @(posedge clk);
    while (sample_stall) @(posedge clk);
    predicted = rms_after(s);
    pending_levels.insert(pending_levels.size(), known ? typed_level : predicted);
  endtask

  function automatic logic signed [IN_W-1:0] pick_sample(input segment_kind_t kind);
    int mag;
    case (kind)
      SEG_QUIET: return IN_W'($urandom_range(512) - 256);
      SEG_LOUD: begin
        mag = 32768 - $urandom_range(64);
        return $urandom_range(1) ? IN_W'(mag) : IN_W'(-mag);
      end
      SEG_FULL_SCALE_NEG: return {1'b1, {(IN_W-1){1'b0}}};
      default: return IN_W'($urandom);
    endcase
  endfunction

  task automatic run_segment(input segment_kind_t kind, input int count,
                             input int send_pct, input int stall_pct);
    send_idle_pct = send_pct;
    level_stall_pct = stall_pct;
    repeat (count) send_sample(pick_sample(kind), 1'b0, '0);
  endtask

  task automatic check_level(input logic [LEVEL_W-1:0] got);
    logic [LEVEL_W-1:0] want;
    if (pending_levels.size() == 0) begin
      $display("%0t: unexpected level word, expected none, got %0d", $time, got);
      fail_count++;
    end else begin
      want = pending_levels.pop_front();
      if (got !== want) begin
        $display("%0t: level mismatch, expected %0d, got %0d", $time, want, got);
        fail_count++;
      end
    end
  endtask

  // result side: check taken words, drive stall with optional long hold-off
  always @(posedge clk) begin
    if (rst) begin
      level_stall <= 1'b0;
    end else begin
      if (level_valid && !level_stall) check_level(level);
      if (start_hold) begin
        hold_left = HOLD_OFF_CYCLES;
        start_hold = 1'b0;
      end
      if (hold_left > 0) begin
        level_stall <= 1'b1;
        hold_left--;
      end else begin
        level_stall <= ($urandom_range(99) < level_stall_pct);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("sliding_window_rms_level_unit test failed");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < WINDOW; i++) window_copy[i] = '0;
    next_slot = 0;
    energy_sum = '0;

    // first three levels follow straight from the empty window
    directed_rows = '{
      '{16'sh8000, 1'b1, 16'd668},
      '{16'sh0000, 1'b1, 16'd668},
      '{16'sh7FFF, 1'b1, 16'd945},
      '{16'shFFFF, 1'b0, 16'd0},
      '{16'sh0001, 1'b0, 16'd0},
      '{16'sh5555, 1'b0, 16'd0},
      '{16'shAAAA, 1'b0, 16'd0},
      '{16'sh8001, 1'b0, 16'd0},
      '{16'sh7FFF, 1'b0, 16'd0},
      '{16'sh8000, 1'b0, 16'd0},
      '{16'sh0000, 1'b0, 16'd0},
      '{16'sh00B5, 1'b0, 16'd0},
      '{16'shFF4B, 1'b0, 16'd0},
      '{16'sh0002, 1'b0, 16'd0},
      '{16'shFFFE, 1'b0, 16'd0},
      '{16'sh7F00, 1'b0, 16'd0},
      '{16'sh00FF, 1'b0, 16'd0},
      '{16'sh4000, 1'b0, 16'd0},
      '{16'shC000, 1'b0, 16'd0},
      '{16'sh0100, 1'b0, 16'd0}
    };

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed rows during warm-up, no idling
    send_idle_pct = 0;
    level_stall_pct = 0;
    foreach (directed_rows[i])
      send_sample(directed_rows[i].value, directed_rows[i].known, directed_rows[i].level);

    // random content under each idling pattern
    run_segment(SEG_FULL_RANGE, 150, 0, 0);
    run_segment(SEG_FULL_RANGE, 150, 79, 0);
    run_segment(SEG_QUIET, 60, 79, 0);
    run_segment(SEG_FULL_RANGE, 150, 0, 79);
    run_segment(SEG_LOUD, 60, 0, 79);
    run_segment(SEG_FULL_RANGE, 150, 28, 28);

    // long hold-off on the result side while samples keep coming
    start_hold = 1'b1;
    run_segment(SEG_FULL_RANGE, 20, 0, 0);
    run_segment(SEG_LOUD, 60, 28, 28);

    // a run of full-scale negative samples
    run_segment(SEG_FULL_SCALE_NEG, 30, 0, 0);
    sample_valid <= 1'b0;

    // drain
    while (pending_levels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("sliding_window_rms_level_unit test passed");
    end else begin
      $display("sliding_window_rms_level_unit test failed");
    end
    $finish;
  end

endmodule
